[rtl/phsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package phsr_pkg;

    // block sizes
    localparam int STAGES       = 6;
    localparam int SINE_ENTRIES = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int INNER_BITS   = SAMPLE_BITS + 8;

    // fixed formats
    localparam int PHASE_BITS = 32;
    localparam int STEP_BITS  = 24;
    localparam int D_BITS     = 16;
    localparam int A1_BITS    = D_BITS + 1;
    localparam int ROM_BITS   = 16;
    localparam int UNITY      = 1 << D_BITS;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_STEP    = 3'd0,
        CFG_SWEEP_LOW     = 3'd1,
        CFG_SWEEP_HIGH    = 3'd2,
        CFG_FEEDBACK_GAIN = 3'd3,
        CFG_WET_MIX       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic               start;
        logic [A1_BITS-1:0] num;
        logic [A1_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [A1_BITS-1:0] quo;
    } div_rsp_t;

    typedef logic signed [ROM_BITS-1:0] sine_rom_t [SINE_ENTRIES];

    // angles in Q30 radians
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;

    // taylor series divisors (2n)(2n+1)
    localparam longint TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    function automatic logic signed [ROM_BITS-1:0] sine_q15(input longint k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        logic   neg;
        neg = 1'b0;
        x = (k * TWO_PI_Q30 + longint'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
        if (x > PI_Q30) begin
            neg = 1'b1;
            x = x - PI_Q30;
        end
        if (x > HALF_PI_Q30) x = PI_Q30 - x;
        if (x < 0) x = 0;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >>> 30) / TAYLOR_DIV[n-1];
            if ((n & 1) != 0) sum = sum - term;
            else sum = sum + term;
        end
        if (sum < 0) sum = 0;
        sum = (sum * 32767 + (longint'(1) << 29)) >>> 30;
        if (sum > 32767) sum = 32767;
        return ROM_BITS'(neg ? -sum : sum);
    endfunction

    function automatic sine_rom_t sine_table();
        sine_rom_t t;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            t[k] = sine_q15(longint'(k));
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/phsr_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle, rounds to nearest
module phsr_div
    import phsr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int NW = A1_BITS + D_BITS;
    localparam int CW = $clog2(A1_BITS + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [A1_BITS-1:0] rem_reg, rem_next;
    logic [A1_BITS-1:0] dvd_reg, dvd_next;
    logic [A1_BITS-1:0] den_reg, den_next;
    logic [A1_BITS-1:0] quo_reg, quo_next;

    logic [NW-1:0]      dividend;
    logic [A1_BITS:0]   trial;
    logic [A1_BITS:0]   trial_diff;
    logic               qbit;

    // num * 2^16 + den / 2
    assign dividend = {req.num, {D_BITS{1'b0}}} + NW'(req.den >> 1);

    assign trial      = {rem_reg, dvd_reg[A1_BITS-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign qbit       = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(A1_BITS);
            rem_next  = A1_BITS'(dividend[NW-1:A1_BITS]);
            dvd_next  = dividend[A1_BITS-1:0];
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = qbit ? trial_diff[A1_BITS-1:0] : trial[A1_BITS-1:0];
            dvd_next = {dvd_reg[A1_BITS-2:0], 1'b0};
            quo_next = {quo_reg[A1_BITS-2:0], qbit};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");

endmodule

`default_nettype wire

[rtl/lfo_swept_allpass_phaser_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// one word at a time: a new input word is taken only in idle, after the output of the last
// word is registered; each word passes the 17-step coefficient divider
//   and the six allpass stages, each a read, two multiplies and a write back
// an output word may wait in its register while the next input word is taken
// reset (synchronous, active low) clears lfo phase, feedback state, stage valid
//   bits and loads the register defaults; stage memory reads as zero until written
module lfo_swept_allpass_phaser_core
    import phsr_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input words
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    // output words
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int IB   = INNER_BITS;
    localparam int MA   = IB + 2;            // multiplier operand a
    localparam int MB   = A1_BITS + 1;       // multiplier operand b
    localparam int PW   = MA + MB;           // product
    localparam int RW   = PW - 15;           // product after rounding by 2^16
    localparam int SW   = RW + 1;            // rounded product plus an addend
    localparam int IDXW = $clog2(SINE_ENTRIES);
    localparam int PHW  = PHASE_BITS + IDXW + 1;
    localparam int SIW  = (STAGES > 1) ? $clog2(STAGES) : 1;

    localparam logic signed [SW-1:0] INNER_MAX = SW'((longint'(1) << (IB - 1)) - 1);
    localparam logic signed [SW-1:0] INNER_MIN = -INNER_MAX - SW'(1);
    localparam logic signed [SW-1:0] SAMPLE_MAX = SW'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [SW-1:0] SAMPLE_MIN = -SAMPLE_MAX - SW'(1);
    localparam logic [A1_BITS-1:0]   ONE_Q16 = A1_BITS'(UNITY);

    localparam sine_rom_t SINE_ROM = sine_table();

    // sequencer, one state per step of the per-word schedule
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_ADDR  = 13'b0000000000010,
        ST_ROM   = 13'b0000000000100,
        ST_DMUL  = 13'b0000000001000,
        ST_DCALC = 13'b0000000010000,
        ST_FB    = 13'b0000000100000,
        ST_DIV   = 13'b0000001000000,
        ST_SRD   = 13'b0000010000000,
        ST_SY    = 13'b0000100000000,
        ST_SMUL  = 13'b0001000000000,
        ST_SWR   = 13'b0010000000000,
        ST_MIX   = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [STEP_BITS-1:0] phase_step_reg;
    logic [D_BITS-1:0]    sweep_low_reg;
    logic [D_BITS-1:0]    sweep_high_reg;
    logic [D_BITS-1:0]    fb_gain_reg;
    logic [A1_BITS-1:0]   wet_mix_reg;

    // datapath state
    logic [PHASE_BITS-1:0]   lfo_phase_reg, lfo_phase_next;
    logic [IDXW-1:0]         rom_idx_reg, rom_idx_next;
    logic signed [ROM_BITS-1:0] rom_q_reg;
    logic signed [SB-1:0]    x_reg, x_next;
    logic signed [IB-1:0]    v_reg, v_next;
    logic signed [IB-1:0]    y_reg, y_next;
    logic signed [IB-1:0]    last_out_reg, last_out_next;
    logic [A1_BITS-1:0]      a1_reg, a1_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic [SIW-1:0]          stg_reg, stg_next;
    logic signed [SB-1:0]    out_reg, out_next;
    logic                    m_valid_reg, m_valid_next;

    // stage memory with registered read and per-entry valid bits
    logic signed [IB-1:0]    stage_mem [STAGES];
    logic signed [IB-1:0]    mem_q_reg;
    logic                    mem_vld_q_reg;
    logic [STAGES-1:0]       stage_vld_reg;
    logic                    mem_rd_en;
    logic                    mem_wr_en;
    logic signed [IB-1:0]    mem_rd;

    // shared multiplier and adder
    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic [PW:0]             prod_bias;
    logic signed [RW-1:0]    prod_rnd;
    logic signed [IB-1:0]    add_opnd;
    logic signed [SW-1:0]    acc_sum;
    logic signed [IB-1:0]    acc_sat;
    logic signed [SB-1:0]    out_sat;

    // lfo index and sweep
    logic [PHW-1:0]          idx_prod;
    logic [IDXW:0]           idx_full;
    logic [IDXW-1:0]         idx_wrap;
    logic [D_BITS-1:0]       rom_u;
    logic signed [D_BITS:0]  sweep_diff;
    logic signed [RW:0]      d_sum;
    logic [D_BITS-1:0]       d_val;
    logic [A1_BITS-1:0]      wet_sat;

    div_req_t div_req;
    div_rsp_t div_rsp;

    function automatic logic signed [IB-1:0] sat_inner(input logic signed [SW-1:0] v);
        if (v > INNER_MAX) return INNER_MAX[IB-1:0];
        if (v < INNER_MIN) return INNER_MIN[IB-1:0];
        return v[IB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] sat_sample(input logic signed [SW-1:0] v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX[SB-1:0];
        if (v < SAMPLE_MIN) return SAMPLE_MIN[SB-1:0];
        return v[SB-1:0];
    endfunction

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;
    assign cfg_ready    = 1'b1;

    // rom index: round(phase * entries / 2^32), a full turn wraps to entry zero
    assign idx_prod = PHW'(lfo_phase_reg) * PHW'(SINE_ENTRIES)
                    + (PHW'(1) << (PHASE_BITS - 1));
    assign idx_full = idx_prod[PHW-1:PHASE_BITS];
    assign idx_wrap = (idx_full == (IDXW + 1)'(SINE_ENTRIES)) ? '0 : idx_full[IDXW-1:0];

    // sine value offset to 0..65535, sweep span may be negative
    assign rom_u      = {~rom_q_reg[ROM_BITS-1], rom_q_reg[ROM_BITS-2:0]};
    assign sweep_diff = $signed({1'b0, sweep_high_reg}) - $signed({1'b0, sweep_low_reg});

    assign wet_sat = (wet_mix_reg > ONE_Q16) ? ONE_Q16 : wet_mix_reg;

    // operand select per step
    always_comb begin
        unique case (state_reg)
            ST_DMUL: begin
                mul_a = MA'(sweep_diff);
                mul_b = $signed({2'b00, rom_u});
            end
            ST_DCALC: begin
                mul_a = MA'(last_out_reg);
                mul_b = $signed({2'b00, fb_gain_reg});
            end
            ST_SRD: begin
                mul_a = -MA'(v_reg);
                mul_b = $signed({1'b0, a1_reg});
            end
            ST_SMUL: begin
                mul_a = MA'(y_reg);
                mul_b = $signed({1'b0, a1_reg});
            end
            ST_MIX, ST_OUT: begin
                // (1-w)*x + w*v  ==  x + w*(v-x), kept while the output waits
                mul_a = MA'(v_reg) - MA'(x_reg);
                mul_b = $signed({1'b0, wet_sat});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round to nearest by 2^16, ties up
    assign prod_bias = {prod_reg[PW-1], prod_reg} + (PW + 1)'(32768);
    assign prod_rnd  = prod_bias[PW:16];

    // delay term from the sweep product, clamped to Q0.16
    assign d_sum = $signed({{(RW + 1 - D_BITS){1'b0}}, sweep_low_reg})
                 + $signed({prod_rnd[RW-1], prod_rnd});
    always_comb begin
        priority if (d_sum < 0) begin
            d_val = '0;
        end else if (d_sum > $signed((RW + 1)'(UNITY - 1))) begin
            d_val = D_BITS'(UNITY - 1);
        end else begin
            d_val = d_sum[D_BITS-1:0];
        end
    end

    // a1 = (1-d)/(1+d)
    assign div_req.start = (state_reg == ST_DCALC);
    assign div_req.num   = ONE_Q16 - {1'b0, d_val};
    assign div_req.den   = ONE_Q16 + {1'b0, d_val};

    phsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign mem_rd = mem_vld_q_reg ? mem_q_reg : '0;

    // addend for the rounded product, per step
    always_comb begin
        unique case (state_reg)
            ST_SY:   add_opnd = mem_rd;
            ST_SWR:  add_opnd = v_reg;
            default: add_opnd = IB'(x_reg);
        endcase
    end

    assign acc_sum = SW'(prod_rnd) + SW'(add_opnd);
    assign acc_sat = sat_inner(acc_sum);
    assign out_sat = sat_sample(acc_sum);

    assign mem_rd_en = (state_reg == ST_SRD);
    assign mem_wr_en = (state_reg == ST_SWR);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        lfo_phase_next = lfo_phase_reg;
        rom_idx_next   = rom_idx_reg;
        x_next         = x_reg;
        v_next         = v_reg;
        y_next         = y_reg;
        last_out_next  = last_out_reg;
        a1_next        = a1_reg;
        stg_next       = stg_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_sample_in;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                // index from the current phase, then advance
                rom_idx_next   = idx_wrap;
                lfo_phase_next = lfo_phase_reg + PHASE_BITS'(phase_step_reg);
                state_next     = ST_ROM;
            end
            ST_ROM: begin
                state_next = ST_DMUL;
            end
            ST_DMUL: begin
                state_next = ST_DCALC;
            end
            ST_DCALC: begin
                // divider starts here, feedback product goes to the multiplier
                state_next = ST_FB;
            end
            ST_FB: begin
                v_next     = acc_sat;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    a1_next    = div_rsp.quo;
                    stg_next   = '0;
                    state_next = ST_SRD;
                end
            end
            ST_SRD: begin
                state_next = ST_SY;
            end
            ST_SY: begin
                y_next     = acc_sat;
                state_next = ST_SMUL;
            end
            ST_SMUL: begin
                state_next = ST_SWR;
            end
            ST_SWR: begin
                // memory takes rnd(y*a1) + v, y feeds the next stage
                v_next = y_reg;
                if (stg_reg == SIW'(STAGES - 1)) begin
                    state_next = ST_MIX;
                end else begin
                    stg_next   = stg_reg + SIW'(1);
                    state_next = ST_SRD;
                end
            end
            ST_MIX: begin
                last_out_next = v_reg;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next     = out_sat;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            lfo_phase_reg <= '0;
            last_out_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            lfo_phase_reg <= lfo_phase_next;
            last_out_reg  <= last_out_next;
        end
        rom_idx_reg <= rom_idx_next;
        x_reg       <= x_next;
        v_reg       <= v_next;
        y_reg       <= y_next;
        a1_reg      <= a1_next;
        stg_reg     <= stg_next;
        out_reg     <= out_next;
        prod_reg    <= prod_next;
    end

    // sine rom, registered read
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROM) begin
            rom_q_reg <= SINE_ROM[rom_idx_reg];
        end
    end

    // stage memory
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            stage_mem[stg_reg] <= acc_sat;
        end
        if (mem_rd_en) begin
            mem_q_reg <= stage_mem[stg_reg];
        end
    end

    // an entry not yet written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= '0;
            mem_vld_q_reg <= 1'b0;
        end else begin
            if (mem_wr_en) begin
                stage_vld_reg[stg_reg] <= 1'b1;
            end
            if (mem_rd_en) begin
                mem_vld_q_reg <= stage_vld_reg[stg_reg];
            end
        end
    end

    // register writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= STEP_BITS'(8948);
            sweep_low_reg  <= D_BITS'(546);
            sweep_high_reg <= D_BITS'(4642);
            fb_gain_reg    <= D_BITS'(45875);
            wet_mix_reg    <= A1_BITS'(19661);
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PHASE_STEP:    phase_step_reg <= cfg_data[STEP_BITS-1:0];
                CFG_SWEEP_LOW:     sweep_low_reg  <= cfg_data[D_BITS-1:0];
                CFG_SWEEP_HIGH:    sweep_high_reg <= cfg_data[D_BITS-1:0];
                CFG_FEEDBACK_GAIN: fb_gain_reg    <= cfg_data[D_BITS-1:0];
                CFG_WET_MIX:       wet_mix_reg    <= cfg_data[A1_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    a_div_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider result outside its wait step");

    a_coef_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRD) |-> (a1_reg <= ONE_Q16))
        else $error("allpass coefficient above one");

    a_stage_index: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (stg_reg <= SIW'(STAGES - 1)))
        else $error("stage index beyond stage count");

endmodule

`default_nettype wire
